// ===== hw/rtl/tcw_pkg.sv =====
// shared types and constants of the text console writer
package tcw_pkg;

	localparam int KIND_W  = 3;
	localparam int CHAR_W  = 8;
	localparam int COORD_W = 11;
	localparam int POS_W   = 16;
	localparam int RROW_W  = 7;
	localparam int RCOL_W  = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [KIND_W-1:0] KIND_WRITE     = 3'd0;
	localparam logic [KIND_W-1:0] KIND_NEWLINE   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_BACKSPACE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_MOVE      = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd4;
	localparam logic [KIND_W-1:0] KIND_READ      = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_FG    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BG    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SHOWN = 2'd2;

	localparam logic [7:0] BLANK_CHAR  = 8'h20;
	localparam logic [7:0] NL_CHAR     = 8'h0A;
	localparam logic [7:0] CLEAR_ATTR  = 8'h0F;
	localparam logic [7:0] SCROLL_ATTR = 8'h00;
	localparam logic [15:0] HIDDEN_POS = 16'hFFFF;

	typedef enum logic [2:0] {
		OP_WRITE,
		OP_NEWLINE,
		OP_BACKSPACE,
		OP_MOVE,
		OP_CLEAR,
		OP_READ,
		OP_NOP
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FILL,
		ST_DIV,
		ST_BSWAIT,
		ST_RDWAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		op_t               op;
		logic [CHAR_W-1:0] char_code;
		logic [POS_W-1:0]  pos;
		logic              rd_ok;
		logic [RROW_W-1:0] rd_row;
		logic [RCOL_W-1:0] rd_col;
	} cmd_t;

endpackage

// ===== hw/rtl/text_console_writer_top.sv =====
// top level of the text console writer
//
// Input words go in through push/full: one is taken at a clock edge with push
// high and full low. Each word yields exactly one result word, shown while empty
// is low and taken at an edge with pop high. A two-word command queue sits
// between the decoder and the executor, so input keeps flowing while a result
// waits to be popped. Configuration writes (cfg_we, cfg_index, cfg_data) take
// effect at once. The user must see that they are made only while the block is
// idle; the block itself does not enforce this. After the queue, each word
// passes the executor states idle, exec and done; reads from a row in use and
// backspace with a read-modify-write add a wait state, moves a divide state,
// and a write into a row not yet touched since a clear or scroll first sweeps
// that row in a fill state, one cell per column. Words run one at a time.
// Clear and scroll need no memory pass: rows carry valid flags and a circular
// base.
// Reset is immediate: all rows read as blank, cursor and latch at zero.
// When pop stays low the executor holds its finished result and the queue
// fills, after which full rises.
module text_console_writer_top #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [tcw_pkg::KIND_W-1:0]          kind,
	input  logic [tcw_pkg::CHAR_W-1:0]          char_code,
	input  logic signed [tcw_pkg::COORD_W-1:0]  col,
	input  logic signed [tcw_pkg::COORD_W-1:0]  row,
	output logic                                empty,
	input  logic                                pop,
	output logic [6:0]                          cursor_col,
	output logic [4:0]                          cursor_row,
	output logic [15:0]                         hw_cursor,
	output logic [7:0]                          cell_char,
	output logic [7:0]                          cell_attr,
	input  logic                                cfg_we,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tcw_pkg::CFG_DATA_W-1:0]      cfg_data
);
	logic          cmd_valid, cmd_pop;
	tcw_pkg::cmd_t cmd;

	tcw_front #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.kind     (kind),
		.char_code(char_code),
		.col      (col),
		.row      (row),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop)
	);

	tcw_back #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.empty     (empty),
		.pop       (pop),
		.cursor_col(cursor_col),
		.cursor_row(cursor_row),
		.hw_cursor (hw_cursor),
		.cell_char (cell_char),
		.cell_attr (cell_attr)
	);
endmodule

// ===== hw/rtl/tcw_ram.sv =====
// generic single write port ram with registered read
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/tcw_front.sv =====
// front end: accepts words, decodes them and queues commands
module tcw_front #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [tcw_pkg::KIND_W-1:0]          kind,
	input  logic [tcw_pkg::CHAR_W-1:0]          char_code,
	input  logic signed [tcw_pkg::COORD_W-1:0]  col,
	input  logic signed [tcw_pkg::COORD_W-1:0]  row,
	output logic                                cmd_valid,
	output tcw_pkg::cmd_t                       cmd,
	input  logic                                cmd_pop
);
	localparam logic signed [21:0] COLS_S  = 22'(COLUMNS);
	localparam logic signed [21:0] CELLS_S = 22'(COLUMNS * ROWS);

	tcw_pkg::cmd_t dec;
	tcw_pkg::cmd_t fifo_q [2];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    count_q;
	logic signed [21:0] pos_s;
	logic          do_push;

	always_comb begin
		dec.char_code = char_code;
		case (kind)
			tcw_pkg::KIND_WRITE:
				dec.op = (char_code == tcw_pkg::NL_CHAR) ? tcw_pkg::OP_NEWLINE : tcw_pkg::OP_WRITE;
			tcw_pkg::KIND_NEWLINE:   dec.op = tcw_pkg::OP_NEWLINE;
			tcw_pkg::KIND_BACKSPACE: dec.op = tcw_pkg::OP_BACKSPACE;
			tcw_pkg::KIND_MOVE:      dec.op = tcw_pkg::OP_MOVE;
			tcw_pkg::KIND_CLEAR:     dec.op = tcw_pkg::OP_CLEAR;
			tcw_pkg::KIND_READ:      dec.op = tcw_pkg::OP_READ;
			default:                 dec.op = tcw_pkg::OP_NOP;
		endcase
		// linear move target, column may spill into neighbor rows
		pos_s = 22'(row) * COLS_S + 22'(col);
		if (pos_s < 0) begin
			dec.pos = '0;
		end else if (pos_s > CELLS_S) begin
			dec.pos = 16'(CELLS_S);
		end else begin
			dec.pos = 16'(pos_s);
		end
		dec.rd_ok = !row[10] && !col[10] && (row[9:0] < 10'(ROWS)) && (col[9:0] < 10'(COLUMNS));
		dec.rd_row = tcw_pkg::RROW_W'(row[9:0]);
		dec.rd_col = tcw_pkg::RCOL_W'(col[9:0]);
	end

	assign full      = (count_q == 2'd2);
	assign do_push   = push && !full;
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(do_push) - 2'(cmd_pop);
		end
	end
endmodule

// ===== hw/rtl/tcw_back.sv =====
// back end: executes commands on the cell memory and holds the result word
module tcw_back #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	input  tcw_pkg::cmd_t                       cmd,
	output logic                                cmd_pop,
	input  logic                                cfg_we,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tcw_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                empty,
	input  logic                                pop,
	output logic [6:0]                          cursor_col,
	output logic [4:0]                          cursor_row,
	output logic [15:0]                         hw_cursor,
	output logic [7:0]                          cell_char,
	output logic [7:0]                          cell_attr
);
	localparam int CELLS = COLUMNS * ROWS;
	localparam int CW  = $clog2(COLUMNS);
	localparam int RW  = $clog2(ROWS + 2);
	localparam int PRW = $clog2(ROWS);
	localparam int AW  = $clog2(CELLS);
	localparam int PW  = $clog2(CELLS + 1);
	// reciprocal of the column count, exact for every position below 2**PW
	localparam int QS  = PW + CW;
	localparam int QM  = ((1 << QS) + COLUMNS - 1) / COLUMNS;
	localparam logic [CW-1:0]  COL_LAST = CW'(COLUMNS - 1);
	localparam logic [RW-1:0]  ROWS_R   = RW'(ROWS);
	localparam logic [RW:0]    ROWS_X   = (RW + 1)'(ROWS);
	localparam logic [PRW-1:0] ROW_LAST = PRW'(ROWS - 1);

	tcw_pkg::state_t state_q, state_d;
	tcw_pkg::cmd_t   cmd_q;
	logic [RW-1:0]   cur_row_q;
	logic [CW-1:0]   cur_col_q;
	logic [PRW-1:0]  base_q;
	logic [ROWS-1:0] row_valid_q, row_scr_q;
	logic [3:0]      fg_q, bg_q;
	logic            shown_q;
	logic [15:0]     latch_q;
	logic [CW-1:0]   fill_cnt_q;
	logic [RW-1:0]   div_quo_q;
	logic [7:0]      rd_char_q, rd_attr_q;
	logic            out_valid_q;
	logic [6:0]      out_col_q;
	logic [4:0]      out_row_q;
	logic [15:0]     out_hw_q;
	logic [7:0]      out_char_q, out_attr_q;

	logic            at_zero, row_in, out_free, tgt_valid;
	logic [RW-1:0]   bs_row, adv_row, nl_row, tgt_row;
	logic [CW-1:0]   bs_col, adv_col, tgt_col, col_sel;
	logic            adv_scroll, nl_scroll;
	logic [RW:0]     row_sum;
	logic [PRW-1:0]  phys_row;
	logic [AW-1:0]   addr;
	logic [15:0]     new_cell, fill_cell, ram_rdata, ram_wdata;
	logic            ram_we;
	logic [PW-1:0]   lin;
	logic [2*PW:0]   quo_prod;
	logic [RW-1:0]   quo;
	logic [PW-1:0]   col_rem;

	// cursor arithmetic
	always_comb begin
		at_zero = (cur_row_q == '0) && (cur_col_q == '0);
		row_in  = (cur_row_q < ROWS_R);
		if (cur_col_q == '0) begin
			bs_row = cur_row_q - RW'(1);
			bs_col = COL_LAST;
		end else begin
			bs_row = cur_row_q;
			bs_col = cur_col_q - CW'(1);
		end
		if (cur_col_q == COL_LAST) begin
			adv_row = cur_row_q + RW'(1);
			adv_col = '0;
		end else begin
			adv_row = cur_row_q;
			adv_col = cur_col_q + CW'(1);
		end
		adv_scroll = (adv_row >= ROWS_R);
		if (adv_scroll) begin
			adv_row = adv_row - RW'(1);
		end
		nl_row    = cur_row_q + RW'(1);
		nl_scroll = (nl_row >= ROWS_R);
		if (nl_scroll) begin
			nl_row = nl_row - RW'(1);
		end
		lin = PW'(cur_row_q) * PW'(COLUMNS) + PW'(cur_col_q);
		// move target split into row and column
		quo_prod = (2 * PW + 1)'(PW'(cmd_q.pos)) * (2 * PW + 1)'(QM);
		quo      = RW'(quo_prod >> QS);
		col_rem  = PW'(cmd_q.pos) - PW'(div_quo_q) * PW'(COLUMNS);
	end

	// cell address through the circular row base
	always_comb begin
		case (cmd_q.op)
			tcw_pkg::OP_READ: begin
				tgt_row = RW'(cmd_q.rd_row);
				tgt_col = CW'(cmd_q.rd_col);
			end
			tcw_pkg::OP_BACKSPACE: begin
				tgt_row = bs_row;
				tgt_col = bs_col;
			end
			default: begin
				tgt_row = cur_row_q;
				tgt_col = cur_col_q;
			end
		endcase
		row_sum  = (RW + 1)'(base_q) + (RW + 1)'(tgt_row);
		phys_row = (row_sum >= ROWS_X) ? PRW'(row_sum - ROWS_X) : PRW'(row_sum);
		col_sel  = (state_q == tcw_pkg::ST_FILL) ? fill_cnt_q : tgt_col;
		addr     = AW'(phys_row) * AW'(COLUMNS) + AW'(col_sel);
		tgt_valid = row_valid_q[phys_row];
		new_cell  = {bg_q, fg_q, cmd_q.char_code};
		fill_cell = {row_scr_q[phys_row] ? tcw_pkg::SCROLL_ATTR : tcw_pkg::CLEAR_ATTR,
			tcw_pkg::BLANK_CHAR};
	end

	assign out_free = !out_valid_q || pop;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tcw_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					state_d = tcw_pkg::ST_EXEC;
				end
			end
			tcw_pkg::ST_EXEC: begin
				case (cmd_q.op)
					tcw_pkg::OP_WRITE:
						state_d = (row_in && !tgt_valid) ? tcw_pkg::ST_FILL : tcw_pkg::ST_DONE;
					tcw_pkg::OP_BACKSPACE:
						state_d = (!at_zero && tgt_valid) ? tcw_pkg::ST_BSWAIT : tcw_pkg::ST_DONE;
					tcw_pkg::OP_MOVE:
						state_d = tcw_pkg::ST_DIV;
					tcw_pkg::OP_READ:
						state_d = (cmd_q.rd_ok && tgt_valid) ? tcw_pkg::ST_RDWAIT : tcw_pkg::ST_DONE;
					default:
						state_d = tcw_pkg::ST_DONE;
				endcase
			end
			tcw_pkg::ST_FILL: begin
				if (fill_cnt_q == COL_LAST) begin
					state_d = tcw_pkg::ST_DONE;
				end
			end
			tcw_pkg::ST_DIV:    state_d = tcw_pkg::ST_DONE;
			tcw_pkg::ST_BSWAIT: state_d = tcw_pkg::ST_DONE;
			tcw_pkg::ST_RDWAIT: state_d = tcw_pkg::ST_DONE;
			tcw_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = tcw_pkg::ST_IDLE;
				end
			end
			default: state_d = tcw_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cmd_pop   = 1'b0;
		ram_we    = 1'b0;
		ram_wdata = new_cell;
		case (state_q)
			tcw_pkg::ST_IDLE: cmd_pop = cmd_valid;
			tcw_pkg::ST_EXEC: begin
				ram_we = (cmd_q.op == tcw_pkg::OP_WRITE) && row_in && tgt_valid;
			end
			tcw_pkg::ST_FILL: begin
				ram_we    = 1'b1;
				ram_wdata = (fill_cnt_q == cur_col_q) ? new_cell : fill_cell;
			end
			tcw_pkg::ST_BSWAIT: begin
				ram_we    = 1'b1;
				ram_wdata = {ram_rdata[15:8], tcw_pkg::BLANK_CHAR};
			end
			default: ;
		endcase
	end

	tcw_ram #(
		.WIDTH(16),
		.DEPTH(CELLS)
	) u_cells (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr),
		.wdata(ram_wdata),
		.raddr(addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcw_pkg::ST_IDLE;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			base_q      <= '0;
			row_valid_q <= '0;
			row_scr_q   <= '0;
			fg_q        <= 4'hF;
			bg_q        <= 4'h0;
			shown_q     <= 1'b1;
			latch_q     <= '0;
			fill_cnt_q  <= '0;
			div_quo_q   <= '0;
			rd_char_q   <= '0;
			rd_attr_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					tcw_pkg::CFG_FG: fg_q <= cfg_data;
					tcw_pkg::CFG_BG: bg_q <= cfg_data;
					tcw_pkg::CFG_SHOWN: begin
						shown_q <= cfg_data[0];
						latch_q <= cfg_data[0] ? 16'(lin) : tcw_pkg::HIDDEN_POS;
					end
					default: ;
				endcase
			end
			case (state_q)
				tcw_pkg::ST_EXEC: begin
					rd_char_q  <= '0;
					rd_attr_q  <= '0;
					fill_cnt_q <= '0;
					case (cmd_q.op)
						tcw_pkg::OP_WRITE: begin
							if (!(row_in && !tgt_valid)) begin
								cur_row_q <= adv_row;
								cur_col_q <= adv_col;
								if (adv_scroll) begin
									row_valid_q[base_q] <= 1'b0;
									row_scr_q[base_q]   <= 1'b1;
									base_q <= (base_q == ROW_LAST) ? '0 : base_q + PRW'(1);
								end
							end
						end
						tcw_pkg::OP_NEWLINE: begin
							cur_row_q <= nl_row;
							cur_col_q <= '0;
							if (nl_scroll) begin
								row_valid_q[base_q] <= 1'b0;
								row_scr_q[base_q]   <= 1'b1;
								base_q <= (base_q == ROW_LAST) ? '0 : base_q + PRW'(1);
							end
						end
						tcw_pkg::OP_BACKSPACE: begin
							// blank row: the cell already reads as space with its attribute
							if (!at_zero && !tgt_valid) begin
								cur_row_q <= bs_row;
								cur_col_q <= bs_col;
							end
						end
						tcw_pkg::OP_MOVE: begin
							div_quo_q <= quo;
						end
						tcw_pkg::OP_CLEAR: begin
							row_valid_q <= '0;
							row_scr_q   <= '0;
							cur_row_q   <= '0;
							cur_col_q   <= '0;
						end
						tcw_pkg::OP_READ: begin
							if (cmd_q.rd_ok && !tgt_valid) begin
								rd_char_q <= fill_cell[7:0];
								rd_attr_q <= fill_cell[15:8];
							end
						end
						default: ;
					endcase
				end
				tcw_pkg::ST_FILL: begin
					fill_cnt_q <= fill_cnt_q + CW'(1);
					if (fill_cnt_q == COL_LAST) begin
						row_valid_q[phys_row] <= 1'b1;
						cur_row_q <= adv_row;
						cur_col_q <= adv_col;
						if (adv_scroll) begin
							row_valid_q[base_q] <= 1'b0;
							row_scr_q[base_q]   <= 1'b1;
							base_q <= (base_q == ROW_LAST) ? '0 : base_q + PRW'(1);
						end
					end
				end
				tcw_pkg::ST_DIV: begin
					// row from the reciprocal multiply, column is what is left
					cur_row_q <= div_quo_q;
					cur_col_q <= CW'(col_rem);
					if (shown_q) begin
						latch_q <= cmd_q.pos;
					end
				end
				tcw_pkg::ST_BSWAIT: begin
					cur_row_q <= bs_row;
					cur_col_q <= bs_col;
				end
				tcw_pkg::ST_RDWAIT: begin
					rd_char_q <= ram_rdata[7:0];
					rd_attr_q <= ram_rdata[15:8];
				end
				default: ;
			endcase
			if (state_q == tcw_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tcw_pkg::ST_DONE && out_free) begin
			out_col_q  <= 7'(cur_col_q);
			out_row_q  <= 5'(cur_row_q);
			out_hw_q   <= latch_q;
			out_char_q <= rd_char_q;
			out_attr_q <= rd_attr_q;
		end
	end

	assign empty      = !out_valid_q;
	assign cursor_col = out_col_q;
	assign cursor_row = out_row_q;
	assign hw_cursor  = out_hw_q;
	assign cell_char  = out_char_q;
	assign cell_attr  = out_attr_q;

	// cursor never goes beyond the one-past-end cell
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_row_q < ROWS_R) || ((cur_row_q == ROWS_R) && (cur_col_q == '0)))
		else $error("cursor beyond one-past-end cell");

	// a finished result waits while the output word is still held
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcw_pkg::ST_DONE && out_valid_q && !pop) |=> (state_q == tcw_pkg::ST_DONE))
		else $error("result dropped while output word held");

	// row fill only for a cursor inside the grid, on a row not yet in use
	a_fill_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tcw_pkg::ST_FILL) |-> (row_in && !tgt_valid))
		else $error("row fill on a valid or out-of-grid row");
endmodule

// ===== dv/tcw_checker.sv =====
// console result checker: tracks screen state, predicts each result word and compares
`timescale 1ns / 1ps
module tcw_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  logic                                full,
	input  logic [tcw_pkg::KIND_W-1:0]          kind,
	input  logic [tcw_pkg::CHAR_W-1:0]          char_code,
	input  logic signed [tcw_pkg::COORD_W-1:0]  col,
	input  logic signed [tcw_pkg::COORD_W-1:0]  row,
	input  logic                                empty,
	input  logic                                pop,
	input  logic [6:0]                          cursor_col,
	input  logic [4:0]                          cursor_row,
	input  logic [15:0]                         hw_cursor,
	input  logic [7:0]                          cell_char,
	input  logic [7:0]                          cell_attr,
	input  logic                                cfg_we,
	input  logic [tcw_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tcw_pkg::CFG_DATA_W-1:0]      cfg_data,
	output int                                  fail_count,
	output int                                  pending_count
);
	localparam int CELLS = COLUMNS * ROWS;

	typedef struct packed {
		logic [6:0]  ccol;
		logic [4:0]  crow;
		logic [15:0] hw;
		logic [7:0]  ch;
		logic [7:0]  attr;
	} console_word_t;

	logic [15:0] screen [CELLS];
	int          cursor;
	logic [15:0] latch;
	logic [3:0]  fg, bg;
	logic        shown;
	console_word_t expected_words [$];

	assign pending_count = expected_words.size();

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	function automatic void reset_screen();
		for (int i = 0; i < CELLS; i++) screen[i] = {tcw_pkg::CLEAR_ATTR, tcw_pkg::BLANK_CHAR};
		cursor = 0;
	endfunction

	function automatic void scroll_if_past();
		if (cursor >= CELLS) begin
			cursor -= COLUMNS;
			for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
			for (int i = CELLS - COLUMNS; i < CELLS; i++)
				screen[i] = {tcw_pkg::SCROLL_ATTR, tcw_pkg::BLANK_CHAR};
		end
	endfunction

	function automatic console_word_t predict_console(input logic [2:0] k, input logic [7:0] c,
			input logic signed [10:0] cl, input logic signed [10:0] rw);
		console_word_t w;
		int pos;
		w = '0;
		if (k == tcw_pkg::KIND_NEWLINE || (k == tcw_pkg::KIND_WRITE && c == tcw_pkg::NL_CHAR)) begin
			cursor = (cursor / COLUMNS + 1) * COLUMNS;
			scroll_if_past();
		end else if (k == tcw_pkg::KIND_WRITE) begin
			if (cursor < CELLS) screen[cursor] = {bg, fg, c};
			cursor++;
			scroll_if_past();
		end else if (k == tcw_pkg::KIND_BACKSPACE) begin
			if (cursor > 0) begin
				cursor--;
				if (cursor < CELLS) screen[cursor][7:0] = tcw_pkg::BLANK_CHAR;
			end
		end else if (k == tcw_pkg::KIND_MOVE) begin
			pos = int'(rw) * COLUMNS + int'(cl);
			if (pos < 0) pos = 0;
			else if (pos > CELLS) pos = CELLS;
			cursor = pos;
			if (shown) latch = cursor[15:0];
		end else if (k == tcw_pkg::KIND_CLEAR) begin
			reset_screen();
		end else if (k == tcw_pkg::KIND_READ) begin
			if (rw >= 0 && rw < ROWS && cl >= 0 && cl < COLUMNS)
				{w.attr, w.ch} = screen[int'(rw) * COLUMNS + int'(cl)];
		end
		w.ccol = 7'(cursor % COLUMNS);
		w.crow = 5'(cursor / COLUMNS);
		w.hw = latch;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		console_word_t want;
		if (!arst_n) begin
			fg = 4'hF;
			bg = 4'h0;
			shown = 1'b1;
			latch = '0;
			reset_screen();
			expected_words.delete();
			fail_count = 0;
		end else begin
			if (pop && !empty) begin
				if (expected_words.size() == 0) begin
					$display("unexpected result word at %0t", $realtime);
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					if (cursor_col !== want.ccol) report_mismatch("cursor_col", cursor_col, want.ccol);
					if (cursor_row !== want.crow) report_mismatch("cursor_row", cursor_row, want.crow);
					if (hw_cursor !== want.hw) report_mismatch("hw_cursor", hw_cursor, want.hw);
					if (cell_char !== want.ch) report_mismatch("cell_char", cell_char, want.ch);
					if (cell_attr !== want.attr) report_mismatch("cell_attr", cell_attr, want.attr);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					tcw_pkg::CFG_FG: fg = cfg_data;
					tcw_pkg::CFG_BG: bg = cfg_data;
					tcw_pkg::CFG_SHOWN: begin
						shown = cfg_data[0];
						latch = shown ? cursor[15:0] : tcw_pkg::HIDDEN_POS;
					end
					default: ;
				endcase
			end
			if (push && !full)
				expected_words.push_back(predict_console(kind, char_code, col, row));
		end
	end
endmodule

// ===== dv/tb.sv =====
// testbench top: drives console words and configuration, gives the verdict
`timescale 1ns / 1ps
module tb;
	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int LIMIT   = 900000;

	logic clk, arst_n;
	logic push, full, empty, pop;
	logic [tcw_pkg::KIND_W-1:0] kind;
	logic [tcw_pkg::CHAR_W-1:0] char_code;
	logic signed [tcw_pkg::COORD_W-1:0] col, row;
	logic [6:0] cursor_col;
	logic [4:0] cursor_row;
	logic [15:0] hw_cursor;
	logic [7:0] cell_char, cell_attr;
	logic cfg_we;
	logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [tcw_pkg::CFG_DATA_W-1:0] cfg_data;
	int fail_count, pending_count;
	int cycles;
	bit hold_pop;
	bit no_idle;

	text_console_writer_top #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (.*);
	tcw_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_checker (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// result side: random stalls plus one long hold-off
	initial begin
		pop = 0;
		forever begin
			@(posedge clk);
			pop <= !hold_pop && (no_idle || $urandom_range(99) >= 19);
		end
	end

	task automatic send_word(input logic [2:0] k, input logic [7:0] c,
			input logic signed [10:0] cl, input logic signed [10:0] rw);
		while (!no_idle && $urandom_range(99) < 19) begin
			push <= 0;
			@(posedge clk);
		end
		push <= 1;
		kind <= k;
		char_code <= c;
		col <= cl;
		row <= rw;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic drain_words();
		push <= 0;
		while (pending_count != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(input logic [tcw_pkg::CFG_IDX_W-1:0] idx, input logic [3:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	task automatic send_random_word();
		int sel;
		logic [2:0] k;
		logic signed [10:0] cl, rw;
		sel = $urandom_range(99);
		if (sel < 55) k = tcw_pkg::KIND_WRITE;
		else if (sel < 65) k = tcw_pkg::KIND_NEWLINE;
		else if (sel < 73) k = tcw_pkg::KIND_BACKSPACE;
		else if (sel < 83) k = tcw_pkg::KIND_MOVE;
		else if (sel < 85) k = tcw_pkg::KIND_CLEAR;
		else if (sel < 98) k = tcw_pkg::KIND_READ;
		else k = 3'($urandom_range(6, 7));
		// mostly on-screen coordinates, sometimes anything
		if ($urandom_range(9) < 8) begin
			cl = 11'($urandom_range(COLUMNS));
			rw = 11'($urandom_range(ROWS));
		end else begin
			cl = 11'($urandom);
			rw = 11'($urandom);
		end
		send_word(k, 8'($urandom), cl, rw);
	endtask

	initial begin
		arst_n = 0;
		push = 0;
		kind = '0;
		char_code = '0;
		col = '0;
		row = '0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		hold_pop = 0;
		no_idle = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: every kind and field extremes
		send_word(tcw_pkg::KIND_BACKSPACE, 8'h00, 0, 0);
		send_word(tcw_pkg::KIND_READ, 8'h00, 0, 0);
		send_word(tcw_pkg::KIND_WRITE, 8'hFF, 0, 0);
		send_word(tcw_pkg::KIND_WRITE, 8'h00, 0, 0);
		send_word(tcw_pkg::KIND_WRITE, tcw_pkg::NL_CHAR, 0, 0);
		send_word(tcw_pkg::KIND_READ, 8'h00, 1, 0);
		send_word(tcw_pkg::KIND_BACKSPACE, 8'h00, 0, 0);
		send_word(tcw_pkg::KIND_READ, 8'h00, -1, 0);
		send_word(tcw_pkg::KIND_READ, 8'h00, COLUMNS, ROWS - 1);
		send_word(tcw_pkg::KIND_READ, 8'h00, 0, ROWS);
		send_word(tcw_pkg::KIND_READ, 8'h00, 11'sh3FF, 11'sh400);
		send_word(tcw_pkg::KIND_MOVE, 8'h00, -1024, -1024);
		send_word(tcw_pkg::KIND_MOVE, 8'h00, 1023, 1023);
		send_word(tcw_pkg::KIND_WRITE, 8'h41, 0, 0);
		send_word(tcw_pkg::KIND_READ, 8'h00, 0, ROWS - 1);
		send_word(tcw_pkg::KIND_MOVE, 8'h00, 150, 2);
		send_word(tcw_pkg::KIND_MOVE, 8'h00, COLUMNS - 1, ROWS - 1);
		send_word(tcw_pkg::KIND_WRITE, 8'h42, 0, 0);
		send_word(tcw_pkg::KIND_READ, 8'h00, COLUMNS - 1, ROWS - 2);
		send_word(tcw_pkg::KIND_MOVE, 8'h00, 0, ROWS);
		send_word(tcw_pkg::KIND_NEWLINE, 8'h00, 0, 0);
		send_word(3'd6, 8'h00, 0, 0);
		send_word(3'd7, 8'hAA, 11'sh2AA, 11'sh555);
		send_word(tcw_pkg::KIND_CLEAR, 8'h00, 0, 0);
		send_word(tcw_pkg::KIND_READ, 8'h00, COLUMNS - 1, ROWS - 1);
		drain_words();

		// phases with different register settings, extremes included
		for (int ph = 0; ph < 7; ph++) begin
			write_reg(tcw_pkg::CFG_FG, ph == 0 ? 4'h0 : ph == 1 ? 4'hF : 4'($urandom));
			write_reg(tcw_pkg::CFG_BG, ph == 0 ? 4'hF : ph == 1 ? 4'h0 : 4'($urandom));
			write_reg(tcw_pkg::CFG_SHOWN, ph[0] ? 4'h0 : 4'h1);
			if (ph == 3) write_reg(2'd3, 4'($urandom));
			no_idle = (ph == 4);
			if (ph == 2) begin
				// long receiver hold-off while words keep coming
				fork
					begin
						hold_pop = 1;
						repeat (300) @(posedge clk);
						hold_pop = 0;
					end
					repeat (20) send_random_word();
				join
			end
			repeat (200) send_random_word();
			drain_words();
		end

		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ram.sv
hw/rtl/tcw_front.sv
hw/rtl/tcw_back.sv
hw/rtl/text_console_writer_top.sv
dv/tcw_checker.sv
dv/tb.sv
